// ===== hw/rtl/b64d_pkg.sv =====
// Shared types, constants and the character classifier of the Base64 stream decoder.
package b64d_pkg;

   localparam int CHAR_W           = 8;
   localparam int SYM_W            = 7;
   localparam int CAP_W            = 16;
   localparam int DCOUNT_W         = 16;
   localparam int COUNT_BITS_DFLT  = 16;
   localparam int QUEUE_DEPTH      = 8;
   localparam int MAX_BYTES        = 3;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd32;

   localparam logic [SYM_W-1:0] PAD_VAL = 7'd64;
   localparam logic [SYM_W-1:0] WS_VAL  = 7'd65;
   localparam logic [SYM_W-1:0] BAD_VAL = 7'd66;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_MALFORMED = 2'd1,
      ST_CAPACITY  = 2'd2
   } status_type;

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              is_terminator;
   } req_type;

   typedef struct packed {
      logic [7:0]          data_byte;
      logic                has_byte;
      logic                done_res;
      status_type          status;
      logic [DCOUNT_W-1:0] decoded_count;
   } rsp_type;

   function automatic logic [SYM_W-1:0] classify(input logic [CHAR_W-1:0] c);
      logic [SYM_W-1:0] v;
      v = BAD_VAL;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v = SYM_W'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = SYM_W'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = SYM_W'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         v = 7'd62;
      end else if (c == 8'h2F) begin
         v = 7'd63;
      end else if (c == 8'h3D) begin
         v = PAD_VAL;
      end else if (c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09) begin
         v = WS_VAL;
      end
      return v;
   endfunction

endpackage

// ===== hw/rtl/base64_stream_decoder.sv =====
// Base64 stream decoder: character intake, quartet assembly, checks and result queue.
//
// Usage: send one text character per req beat, then a beat with is_terminator set.
// Whitespace is skipped; each complete quartet yields one to three rsp beats carrying a
// decoded byte and the running count. The terminator yields a single rsp beat with
// done_res set, the status and the decoded length, after which the next text starts.
// After any error, characters are dropped silently until the terminator.
// csr carries output_capacity; write it only while the block is idle. csr_ready is
// always high.
// Results are registered in the result queue and offered on rsp from its head.
// Throughput: one character per cycle while req_stall is low; each beat is decoded
// combinationally into an eight-entry result queue that drains one beat per cycle while
// rsp_stall is low. req_stall rises only while the queue cannot take three more results.
// When the receiver stalls, the queue head holds and fills; intake resumes as it drains.
// Reset (synchronous) empties the queue, clears the quartet, count and error state
// and sets output_capacity to 32.
module base64_stream_decoder
   import b64d_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DFLT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (COUNT_BITS + 1 > CAP_W + 1) ? COUNT_BITS + 1 : CAP_W + 1;
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(QUEUE_DEPTH - MAX_BYTES);

   logic [CAP_W-1:0]      capacity_ff;
   logic [SYM_W-1:0]      quartet_ff [MAX_BYTES];
   logic [SYM_W-1:0]      quartet_in [MAX_BYTES];
   logic [1:0]            fill_ff, fill_in;
   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in;
   status_type            error_ff, error_in;

   rsp_type               queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  req_acc, rsp_acc;
   logic [1:0]            push_n;
   rsp_type               push_data [MAX_BYTES];
   logic [PTR_W-1:0]      wr_idx [MAX_BYTES];

   logic [SYM_W-1:0]      sym, v0, v1, v2, v3;
   logic [5:0]            v2m, v3m;
   logic [7:0]            b0, b1, b2;
   logic [1:0]            n_bytes;
   logic [CMP_W-1:0]      next_count;
   logic [COUNT_BITS-1:0] cnt1, cnt2, cnt3;
   status_type            term_status;

   assign req_stall = count_ff > ROOM_LIMIT;
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = count_ff != '0;
   assign rsp_acc   = rsp_valid && !rsp_stall;
   assign rsp_payload = queue_ff[rd_ptr_ff];
   assign csr_ready = 1'b1;

   assign sym = classify(req_payload.text_char);
   assign v0  = quartet_ff[0];
   assign v1  = quartet_ff[1];
   assign v2  = quartet_ff[2];
   assign v3  = sym;
   assign v2m = (v2 == PAD_VAL) ? 6'd0 : v2[5:0];
   assign v3m = (v3 == PAD_VAL) ? 6'd0 : v3[5:0];
   assign b0  = {v0[5:0], v1[5:4]};
   assign b1  = {v1[3:0], v2m[5:2]};
   assign b2  = {v2m[1:0], v3m};
   assign n_bytes = (v2 == PAD_VAL) ? 2'd1 : ((v3 == PAD_VAL) ? 2'd2 : 2'd3);
   assign next_count = CMP_W'(byte_count_ff) + CMP_W'(n_bytes);
   assign cnt1 = byte_count_ff + COUNT_BITS'(1);
   assign cnt2 = byte_count_ff + COUNT_BITS'(2);
   assign cnt3 = byte_count_ff + COUNT_BITS'(3);
   assign term_status = (error_ff == ST_OK && fill_ff != 2'd0) ? ST_MALFORMED : error_ff;

   always_comb begin
      quartet_in    = quartet_ff;
      fill_in       = fill_ff;
      byte_count_in = byte_count_ff;
      error_in      = error_ff;
      push_n        = 2'd0;
      for (int k = 0; k < MAX_BYTES; k++) begin
         push_data[k] = '{data_byte: 8'd0, has_byte: 1'b1, done_res: 1'b0,
                          status: ST_OK, decoded_count: '0};
      end
      push_data[0].data_byte     = b0;
      push_data[1].data_byte     = b1;
      push_data[2].data_byte     = b2;
      push_data[0].decoded_count = DCOUNT_W'(cnt1);
      push_data[1].decoded_count = DCOUNT_W'(cnt2);
      push_data[2].decoded_count = DCOUNT_W'(cnt3);

      if (req_acc) begin
         if (req_payload.is_terminator) begin
            push_n       = 2'd1;
            push_data[0] = '{data_byte: 8'd0, has_byte: 1'b0, done_res: 1'b1,
                             status: term_status,
                             decoded_count: DCOUNT_W'(byte_count_ff)};
            for (int k = 0; k < MAX_BYTES; k++) begin
               quartet_in[k] = '0;
            end
            fill_in       = 2'd0;
            byte_count_in = '0;
            error_in      = ST_OK;
         end else if (error_ff == ST_OK && sym != WS_VAL) begin
            if (sym == BAD_VAL) begin
               error_in = ST_MALFORMED;
            end else if (fill_ff != 2'd3) begin
               quartet_in[fill_ff] = sym;
               fill_in = fill_ff + 2'd1;
            end else begin
               fill_in = 2'd0;
               if (v0 == PAD_VAL || v1 == PAD_VAL ||
                   (v2 == PAD_VAL && v3 != PAD_VAL)) begin
                  error_in = ST_MALFORMED;
               end else if (next_count > CMP_W'(capacity_ff) || next_count[COUNT_BITS]) begin
                  error_in = ST_CAPACITY;
               end else begin
                  push_n        = n_bytes;
                  byte_count_in = COUNT_BITS'(next_count);
               end
            end
         end
      end

      for (int k = 0; k < MAX_BYTES; k++) begin
         wr_idx[k] = wr_ptr_ff + PTR_W'(k);
      end
      count_in = count_ff + CNT_W'(push_n) - CNT_W'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAPACITY_RESET;
         for (int k = 0; k < MAX_BYTES; k++) begin
            quartet_ff[k] <= '0;
         end
         fill_ff       <= 2'd0;
         byte_count_ff <= '0;
         error_ff      <= ST_OK;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
         quartet_ff    <= quartet_in;
         fill_ff       <= fill_in;
         byte_count_ff <= byte_count_in;
         error_ff      <= error_in;
         wr_ptr_ff     <= wr_ptr_ff + PTR_W'(push_n);
         rd_ptr_ff     <= rd_ptr_ff + PTR_W'(rsp_acc);
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_BYTES; k++) begin
         if (k < int'(push_n)) begin
            queue_ff[wr_idx[k]] <= push_data[k];
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_room_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> count_ff <= ROOM_LIMIT)
      else $error("beat taken without room for its results");

   a_error_no_bytes: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !req_payload.is_terminator && error_ff != ST_OK) |=>
         count_ff <= $past(count_ff))
      else $error("bytes produced after an error");

   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_payload.is_terminator) |=>
         (fill_ff == 2'd0 && byte_count_ff == '0 && error_ff == ST_OK))
      else $error("text state not cleared after terminator");

   a_count_tracks_bytes: assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0 && !req_payload.is_terminator) |=>
         byte_count_ff == $past(byte_count_ff) + COUNT_BITS'($past(push_n)))
      else $error("byte count out of step with bytes pushed");
`endif

endmodule
